// ===== rtl/core/serial_bit_poke_command_parser_top_assert.svh =====
// assertion macros used by the parser rtl
`ifndef SERIAL_BIT_POKE_COMMAND_PARSER_TOP_ASSERT_SVH
`define SERIAL_BIT_POKE_COMMAND_PARSER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SBP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SBP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sbp_pkg.sv =====
`default_nettype none

package sbp_pkg;

    localparam int SBP_TOKEN_DEPTH = 16;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_F = 8'h66;

    localparam logic [3:0] DIGIT_ONE = 4'd1;

    typedef logic [2:0] event_t;
    localparam event_t EV_STORED   = 3'd0;
    localparam event_t EV_ADDR     = 3'd1;
    localparam event_t EV_POS      = 3'd2;
    localparam event_t EV_WRITE    = 3'd3;
    localparam event_t EV_INVALID  = 3'd4;
    localparam event_t EV_OVERFLOW = 3'd5;

    typedef logic [1:0] role_t;
    localparam role_t ROLE_ADDR  = 2'd0;
    localparam role_t ROLE_POS   = 2'd1;
    localparam role_t ROLE_VALUE = 2'd2;

    // parser state apart from the token length
    typedef struct packed {
        role_t       role;
        logic [3:0]  first_digit;
        logic [3:0]  second_digit;
        logic        token_all_hex;
        logic [7:0]  held_address;
        logic [3:0]  held_bit_position;
    } parse_state_t;

    typedef struct packed {
        event_t      event_res;
        logic        write_strobe;
        logic [7:0]  port_addr;
        logic [7:0]  dir_addr;
        logic [7:0]  bit_mask;
        logic        bit_value;
    } result_t;

    localparam int RESULT_DATA_W = 32;

    // bit 4 set when the character is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] h;
        h = 5'h10;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            h = {1'b0, 4'(c - CHAR_ZERO)};
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            h = {1'b0, 4'(c - CHAR_UP_A + 8'd10)};
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
            h = {1'b0, 4'(c - CHAR_LOW_A + 8'd10)};
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbp_step.sv =====
`default_nettype none

module sbp_step import sbp_pkg::*; #(
    parameter int TOKEN_DEPTH = SBP_TOKEN_DEPTH,
    parameter int LEN_W       = $clog2(TOKEN_DEPTH)
) (
    input  wire logic [7:0]       rx_char,
    input  wire parse_state_t     state_cur,
    input  wire logic [LEN_W-1:0] token_len_cur,
    output parse_state_t          state_nxt,
    output logic [LEN_W-1:0]      token_len_nxt,
    output result_t               result
);

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(TOKEN_DEPTH - 1);

    logic [4:0] hex;

    always_comb begin
        hex           = hex_value(rx_char);
        state_nxt     = state_cur;
        token_len_nxt = token_len_cur;
        result        = '0;
        result.event_res = EV_STORED;

        if (rx_char == CHAR_COLON) begin
            if (!state_cur.token_all_hex) begin
                result.event_res = EV_INVALID;
            end else begin
                unique case (state_cur.role)
                    ROLE_POS: begin
                        state_nxt.held_bit_position = state_cur.first_digit;
                        state_nxt.role   = ROLE_VALUE;
                        result.event_res = EV_POS;
                    end
                    ROLE_VALUE: begin
                        result.port_addr    = state_cur.held_address;
                        result.dir_addr     = state_cur.held_address - 8'd1;
                        result.bit_mask     = state_cur.held_bit_position[3] ? 8'h00
                                            : (8'h01 << state_cur.held_bit_position[2:0]);
                        result.bit_value    = (state_cur.first_digit == DIGIT_ONE);
                        result.write_strobe = 1'b1;
                        state_nxt.role      = ROLE_ADDR;
                        result.event_res    = EV_WRITE;
                    end
                    // address role, also taken by the unused role code
                    default: begin
                        state_nxt.held_address = {state_cur.first_digit,
                                                  state_cur.second_digit};
                        state_nxt.role   = ROLE_POS;
                        result.event_res = EV_ADDR;
                    end
                endcase
            end
            token_len_nxt           = '0;
            state_nxt.first_digit   = '0;
            state_nxt.second_digit  = '0;
            state_nxt.token_all_hex = 1'b1;
        end else if (token_len_cur < LEN_LIMIT) begin
            if (hex[4]) begin
                state_nxt.token_all_hex = 1'b0;
            end else if (token_len_cur == '0) begin
                state_nxt.first_digit = hex[3:0];
            end else if (token_len_cur == LEN_W'(1)) begin
                state_nxt.second_digit = hex[3:0];
            end
            token_len_nxt = token_len_cur + 1'b1;
        end else begin
            // token too long: drop the character and start over
            token_len_nxt           = '0;
            state_nxt.first_digit   = '0;
            state_nxt.second_digit  = '0;
            state_nxt.token_all_hex = 1'b1;
            result.event_res        = EV_OVERFLOW;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/serial_bit_poke_command_parser_top.sv =====
// serial bit-poke command parser
// s_ channel: one received ascii character per request in s_tdata[7:0].
// characters gather into tokens ended by ':'; tokens take the roles port
// address, bit position and bit value in turn. every character gives
// exactly one result on the m_ channel: event code, and on the third
// token a write strobe with port address, direction address (port - 1),
// one-hot bit mask (zero for a position above 7) and bit value.
// the result is registered, in the result register or, while a result
// waits, in the skid stage. throughput: one character per cycle while
// s_tready is high; the parse step that updates the token state between
// an input request and the result register is combinational.
// a one-entry skid stage sits behind the result register, so one more
// character is taken while a result waits; s_tready drops only when both
// are full and stays low until m_tready takes a result.
// reset (aresetn low, synchronous): no results pending, role back to
// address, token empty, held address and bit position zero.
`default_nettype none

`include "serial_bit_poke_command_parser_top_assert.svh"

module serial_bit_poke_command_parser_top import sbp_pkg::*; #(
    parameter int TOKEN_DEPTH = SBP_TOKEN_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,  // [7:0] rx_char
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [2:0] event_res, [3] write_strobe, [11:4] port_addr, [19:12] dir_addr,
    // [27:20] bit_mask, [28] bit_value, [31:29] zero
    output logic [RESULT_DATA_W-1:0]      m_tdata
);

    localparam int LEN_W = $clog2(TOKEN_DEPTH);

    parse_state_t     state_reg, state_next;
    logic [LEN_W-1:0] token_len_reg, token_len_next;
    result_t          step_result;

    result_t main_reg, main_next;
    logic    main_valid_reg, main_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic s_accept;
    logic m_accept;

    sbp_step #(
        .TOKEN_DEPTH (TOKEN_DEPTH),
        .LEN_W       (LEN_W)
    ) u_step (
        .rx_char       (s_tdata),
        .state_cur     (state_reg),
        .token_len_cur (token_len_reg),
        .state_nxt     (state_next),
        .token_len_nxt (token_len_next),
        .result        (step_result)
    );

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = main_valid_reg;
    assign m_accept = main_valid_reg && m_tready;

    assign m_tdata = {3'b000, main_reg.bit_value, main_reg.bit_mask, main_reg.dir_addr,
                      main_reg.port_addr, main_reg.write_strobe, main_reg.event_res};

    always_comb begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!main_valid_reg || m_accept) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_next       = step_result;
                skid_valid_next = s_accept;
            end else begin
                main_next       = step_result;
                main_valid_next = s_accept;
            end
        end else if (s_accept) begin
            skid_next       = step_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.role              <= ROLE_ADDR;
            state_reg.first_digit       <= '0;
            state_reg.second_digit      <= '0;
            state_reg.token_all_hex     <= 1'b1;
            state_reg.held_address      <= '0;
            state_reg.held_bit_position <= '0;
            token_len_reg               <= '0;
            main_valid_reg              <= 1'b0;
            skid_valid_reg              <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg     <= state_next;
                token_len_reg <= token_len_next;
            end
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `SBP_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_accept, m_tvalid,
        "accepted character produced no pending result")
    `SBP_ASSERT_NEXT(a_colon_clears_token, aclk, aresetn, s_accept && s_tdata == CHAR_COLON,
        token_len_reg == '0 && state_reg.token_all_hex, "token not cleared after separator")
    `SBP_ASSERT_NOW(a_strobe_only_on_write, aclk, aresetn, m_tvalid && main_reg.write_strobe,
        main_reg.event_res == EV_WRITE, "write strobe on a non-write event")
    `SBP_ASSERT_NOW(a_dir_below_port, aclk, aresetn, m_tvalid && main_reg.write_strobe,
        main_reg.dir_addr == main_reg.port_addr - 8'd1, "direction address not port minus one")
    `SBP_ASSERT_NEXT(a_write_returns_to_addr, aclk, aresetn,
        s_accept && step_result.event_res == EV_WRITE, state_reg.role == ROLE_ADDR,
        "role did not return to address after a write")

endmodule

`default_nettype wire

// ===== dv/tb_serial_bit_poke_command_parser_top.sv =====
`default_nettype none

module tb_serial_bit_poke_command_parser_top;
    import sbp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_CHARS = 1250;
    localparam int MAX_WAIT = 19;
    localparam int MAX_PRINTED = 50;

    typedef struct {
        logic [7:0] ch;
        bit         drain;
    } rx_req_t;

    typedef struct {
        event_t     ev;
        logic       strobe;
        logic [7:0] port_addr;
        logic [7:0] dir_addr;
        logic [7:0] mask;
        logic       value;
    } poke_result_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [RESULT_DATA_W-1:0] m_tdata;

    rx_req_t char_q[$];
    poke_result_t poke_q[$];
    int n_chars = 0;
    int pending = 0;
    int error_count = 0;
    int cycle_count = 0;
    int tx_wait = 0;
    int rx_wait = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit feed_idle = 1'b0;

    // parser state as the predictor sees it
    role_t cur_role;
    int tok_len;
    logic [3:0] tok_d0;
    logic [3:0] tok_d1;
    bit tok_hex;
    logic [7:0] held_addr;
    logic [3:0] held_pos;

    serial_bit_poke_command_parser_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UP_A && c <= CHAR_UP_F)
            || (c >= CHAR_LOW_A && c <= CHAR_LOW_F);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return CHAR_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LOW_A) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_hex(c) || c == CHAR_COLON);
        return c;
    endfunction

    // one character through the parser, returns the result it must produce
    function automatic poke_result_t parse_char(input logic [7:0] c);
        poke_result_t r;
        logic [3:0] d;
        r = '{EV_STORED, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0};
        if (c == CHAR_COLON) begin
            if (!tok_hex) begin
                r.ev = EV_INVALID;
            end else begin
                case (cur_role)
                    ROLE_POS: begin
                        held_pos = tok_d0;
                        cur_role = ROLE_VALUE;
                        r.ev = EV_POS;
                    end
                    ROLE_VALUE: begin
                        r.ev = EV_WRITE;
                        r.strobe = 1'b1;
                        r.port_addr = held_addr;
                        r.dir_addr = held_addr - 8'd1;
                        r.mask = held_pos[3] ? 8'h00 : 8'h01 << held_pos[2:0];
                        r.value = (tok_d0 == DIGIT_ONE);
                        cur_role = ROLE_ADDR;
                    end
                    default: begin
                        held_addr = {tok_d0, tok_d1};
                        cur_role = ROLE_POS;
                        r.ev = EV_ADDR;
                    end
                endcase
            end
            tok_len = 0;
            tok_d0 = '0;
            tok_d1 = '0;
            tok_hex = 1'b1;
        end else if (tok_len < SBP_TOKEN_DEPTH - 1) begin
            if (!is_hex(c)) begin
                tok_hex = 1'b0;
            end else begin
                if (c <= CHAR_NINE) d = 4'(c - CHAR_ZERO);
                else if (c <= CHAR_UP_F) d = 4'(c - CHAR_UP_A + 8'd10);
                else d = 4'(c - CHAR_LOW_A + 8'd10);
                if (tok_len == 0) tok_d0 = d;
                else if (tok_len == 1) tok_d1 = d;
            end
            tok_len++;
        end else begin
            // character dropped, token starts over in the same role
            tok_len = 0;
            tok_d0 = '0;
            tok_d1 = '0;
            tok_hex = 1'b1;
            r.ev = EV_OVERFLOW;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (error_count < MAX_PRINTED)
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic add_char(input logic [7:0] c);
        char_q.push_back('{c, 1'b0});
        n_chars++;
    endtask

    task automatic add_drain();
        char_q.push_back('{8'h00, 1'b1});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic add_hex_token(input int unsigned ndig, input bit value_role);
        for (int unsigned i = 0; i < ndig; i++) begin
            if (i == 0 && value_role && $urandom_range(0, 1))
                add_char(CHAR_ZERO + 8'd1);
            else
                add_char(hex_char(4'($urandom_range(0, 15))));
        end
        add_char(CHAR_COLON);
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            tx_wait <= 0;
            feed_idle <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tx_wait > 0) begin
                tx_wait <= tx_wait - 1;
                s_tvalid <= 1'b0;
            end else if (char_q.size() != 0 && char_q[0].drain) begin
                // hold off until every result is back
                s_tvalid <= 1'b0;
                if (pending == 0 && !(s_tvalid && s_tready)) void'(char_q.pop_front());
            end else if (char_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= char_q.pop_front().ch;
                tx_wait <= draw_wait(tx_quiet);
                if ($urandom_range(0, 63) == 0) tx_quiet <= !tx_quiet;
            end else begin
                s_tvalid <= 1'b0;
                feed_idle <= 1'b1;
            end
        end
    end

    // receiver ready
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            w = draw_wait(rx_quiet);
            rx_wait <= w;
            m_tready <= (w == 0);
            if ($urandom_range(0, 63) == 0) rx_quiet <= !rx_quiet;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // prediction on each accepted character, check on each accepted result
    always @(posedge aclk) begin
        poke_result_t want;
        if (!aresetn) begin
            cur_role = ROLE_ADDR;
            tok_len = 0;
            tok_d0 = '0;
            tok_d1 = '0;
            tok_hex = 1'b1;
            held_addr = '0;
            held_pos = '0;
            pending <= 0;
        end else begin
            if (s_tvalid && s_tready) poke_q.push_back(parse_char(s_tdata));
            if (m_tvalid && m_tready) begin
                if (poke_q.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata, 0);
                end else begin
                    want = poke_q.pop_front();
                    if (m_tdata[2:0] !== want.ev)
                        report_mismatch("event_res", m_tdata[2:0], want.ev);
                    if (m_tdata[3] !== want.strobe)
                        report_mismatch("write_strobe", m_tdata[3], want.strobe);
                    if (m_tdata[11:4] !== want.port_addr)
                        report_mismatch("port_addr", m_tdata[11:4], want.port_addr);
                    if (m_tdata[19:12] !== want.dir_addr)
                        report_mismatch("dir_addr", m_tdata[19:12], want.dir_addr);
                    if (m_tdata[27:20] !== want.mask)
                        report_mismatch("bit_mask", m_tdata[27:20], want.mask);
                    if (m_tdata[28] !== want.value)
                        report_mismatch("bit_value", m_tdata[28], want.value);
                    if (m_tdata[31:29] !== 3'b000)
                        report_mismatch("padding", m_tdata[31:29], 0);
                end
            end
            pending <= poke_q.size();
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int pick;
        int len;
        int junk_at;

        // empty tokens, all-f address with position above 7, invalid tokens
        add_text(":");
        add_text(":");
        add_text("1:");
        add_text("fF:");
        add_text("F:");
        add_text("10:");
        add_text("A9");
        add_char(8'h00);
        add_text(":");
        add_text("09:");
        add_text("7:");
        add_char(8'hFF);
        add_text(":");
        add_text("0:");
        add_drain();

        while (n_chars < RANDOM_CHARS + 25) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // well-formed address, position, value
                add_hex_token($urandom_range(0, 9) == 0 ? $urandom_range(0, 6)
                                                        : $urandom_range(0, 3), 1'b0);
                add_hex_token($urandom_range(0, 2), 1'b0);
                add_hex_token($urandom_range(0, 3), 1'b1);
            end else if (pick < 80) begin
                // token broken by a non-hex character
                len = $urandom_range(1, 4);
                junk_at = $urandom_range(0, len - 1);
                for (int i = 0; i < len; i++)
                    add_char(i == junk_at ? junk_char() : hex_char(4'($urandom_range(0, 15))));
                add_char(CHAR_COLON);
            end else if (pick < 88) begin
                // around the token length limit
                len = $urandom_range(SBP_TOKEN_DEPTH - 2, SBP_TOKEN_DEPTH + 1);
                for (int i = 0; i < len; i++)
                    add_char($urandom_range(0, 3) == 0 ? junk_char()
                                                       : hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 1)) add_char(CHAR_COLON);
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 99) == 0) add_drain();
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (!(feed_idle && !s_tvalid && pending == 0)) @(posedge aclk);
        repeat (8) @(posedge aclk);
        while (poke_q.size() != 0) begin
            report_mismatch("result never came, event_res", 0, poke_q[0].ev);
            void'(poke_q.pop_front());
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
